>>> rtl/mhpu_pkg.sv
package mhpu_pkg;

   localparam int CAPACITY     = 1024;
   localparam int HANDLE_WIDTH = 16;
   localparam int POS_WIDTH    = 10;
   localparam int KEY_WIDTH    = 64;
   localparam int COUNT_WIDTH  = 11;

   typedef struct packed {
      logic [KEY_WIDTH-1:0]    key;
      logic [HANDLE_WIDTH-1:0] handle;
      logic                    handle_valid;
   } entry_type;

   localparam int ENTRY_WIDTH = $bits(entry_type);

endpackage

>>> rtl/mhpu_req_if.sv
interface mhpu_req_if;
   import mhpu_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [POS_WIDTH-1:0]    position;
   logic [KEY_WIDTH-1:0]    key;
   logic [HANDLE_WIDTH-1:0] handle;
   logic                    handle_valid;
   logic [COUNT_WIDTH-1:0]  entry_count;

   modport source (output valid, position, key, handle, handle_valid, entry_count,
                   input ready);
   modport sink   (input valid, position, key, handle, handle_valid, entry_count,
                   output ready);
endinterface

>>> rtl/mhpu_rsp_if.sv
interface mhpu_rsp_if;
   import mhpu_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [HANDLE_WIDTH-1:0] moved_handle;
   logic                    moved_handle_valid;
   logic [POS_WIDTH-1:0]    new_position;
   logic                    last;

   modport source (output valid, moved_handle, moved_handle_valid, new_position, last,
                   input ready);
   modport sink   (input valid, moved_handle, moved_handle_valid, new_position, last,
                   output ready);
endinterface

>>> rtl/min_heap_position_update_core.sv
// Sift up reads one parent per level; sift down reads the left child, then the right child,
// then compares and writes back, all on the single heap RAM port pair.
// Reset clears the sequencer and the result valid flag; heap slots stay undefined until written.
module min_heap_position_update_core (
   input  logic       clock,
   input  logic       reset,
   mhpu_req_if.sink   req_chan,
   mhpu_rsp_if.source rsp_chan
);
   import mhpu_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_UP     = 3'd1;
   localparam logic [2:0] S_DN_L   = 3'd2;
   localparam logic [2:0] S_DN_R   = 3'd3;
   localparam logic [2:0] S_DN_CMP = 3'd4;
   localparam logic [2:0] S_FINAL  = 3'd5;

   logic [2:0]             state_ff, state_in;
   logic [POS_WIDTH-1:0]   pos_ff, pos_in;
   logic [KEY_WIDTH-1:0]   key_ff;
   logic [HANDLE_WIDTH-1:0] hnd_ff;
   logic                   hv_ff;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic                   first_ff, first_in;
   entry_type              left_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [HANDLE_WIDTH-1:0] rsp_handle_ff;
   logic                    rsp_hv_ff;
   logic [POS_WIDTH-1:0]    rsp_pos_ff;
   logic                    rsp_last_ff;

   logic                   wr_en, rd_en;
   logic [POS_WIDTH-1:0]   wr_addr, rd_addr;
   entry_type              wr_data, rd_data;

   logic                   accept, out_free, emit, emit_last;
   entry_type              emit_entry;
   logic [COUNT_WIDTH-1:0] req_count;
   logic [POS_WIDTH-1:0]   par, gpar, req_par;
   logic [COUNT_WIDTH-1:0] left_idx, best_left;
   logic [COUNT_WIDTH:0]   right_idx;
   logic                   left_ok, right_ok, best_left_ok;
   logic [POS_WIDTH-1:0]   best_pos;
   entry_type              best_entry;
   logic                   best_moves;
   entry_type              own_entry;

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);

   assign req_count = (req_chan.entry_count > COUNT_WIDTH'(CAPACITY)) ?
                      COUNT_WIDTH'(CAPACITY) : req_chan.entry_count;
   assign req_par   = (req_chan.position - POS_WIDTH'(1)) >> 1;
   assign par       = (pos_ff - POS_WIDTH'(1)) >> 1;
   assign gpar      = (par - POS_WIDTH'(1)) >> 1;

   assign left_idx  = {pos_ff, 1'b1};
   assign right_idx = {1'b0, pos_ff, 1'b0} + (COUNT_WIDTH + 1)'(2);
   assign left_ok   = left_idx < count_ff;
   assign right_ok  = right_idx < {1'b0, count_ff};

   assign own_entry = '{key: key_ff, handle: hnd_ff, handle_valid: hv_ff};

   // Pick the winning child; the right one must beat both the key and the left
   always_comb begin
      best_pos   = pos_ff;
      best_entry = own_entry;
      best_moves = 1'b0;
      if (left_ff.key < key_ff) begin
         best_pos   = left_idx[POS_WIDTH-1:0];
         best_entry = left_ff;
         best_moves = 1'b1;
      end
      if (right_ok && (rd_data.key < best_entry.key)) begin
         best_pos   = right_idx[POS_WIDTH-1:0];
         best_entry = rd_data;
         best_moves = 1'b1;
      end
   end

   assign best_left    = {best_pos, 1'b1};
   assign best_left_ok = best_left < count_ff;

   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      first_in   = first_ff;
      rd_en      = 1'b0;
      rd_addr    = par;
      wr_en      = 1'b0;
      wr_addr    = pos_ff;
      wr_data    = own_entry;
      emit       = 1'b0;
      emit_last  = 1'b0;
      emit_entry = own_entry;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pos_in   = req_chan.position;
               first_in = 1'b1;
               if ({1'b0, req_chan.position} >= req_count) begin
                  state_in = S_FINAL;
               end else if (req_chan.position != '0) begin
                  rd_en    = 1'b1;
                  rd_addr  = req_par;
                  state_in = S_UP;
               end else begin
                  state_in = S_DN_L;
               end
            end
         end
         S_UP: begin
            if (rd_data.key > key_ff) begin
               if (out_free) begin
                  emit       = 1'b1;
                  emit_entry = rd_data;
                  wr_en      = 1'b1;
                  wr_data    = rd_data;
                  pos_in     = par;
                  first_in   = 1'b0;
                  if (par != '0) begin
                     rd_en   = 1'b1;
                     rd_addr = gpar;
                  end else begin
                     state_in = S_FINAL;
                  end
               end
            end else if (first_ff) begin
               state_in = S_DN_L;
            end else begin
               state_in = S_FINAL;
            end
         end
         S_DN_L: begin
            if (left_ok) begin
               rd_en    = 1'b1;
               rd_addr  = left_idx[POS_WIDTH-1:0];
               state_in = S_DN_R;
            end else begin
               state_in = S_FINAL;
            end
         end
         S_DN_R: begin
            rd_en    = right_ok;
            rd_addr  = right_idx[POS_WIDTH-1:0];
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            if (!best_moves) begin
               state_in = S_FINAL;
            end else if (out_free) begin
               emit       = 1'b1;
               emit_entry = best_entry;
               wr_en      = 1'b1;
               wr_data    = best_entry;
               pos_in     = best_pos;
               state_in   = best_left_ok ? S_DN_L : S_FINAL;
            end
         end
         S_FINAL: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_last = 1'b1;
               wr_en     = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      first_ff <= first_in;
      if (accept) begin
         key_ff   <= req_chan.key;
         hnd_ff   <= req_chan.handle;
         hv_ff    <= req_chan.handle_valid;
         count_ff <= req_count;
      end
      // hold the left child while the right one is fetched
      if (state_ff == S_DN_R) begin
         left_ff <= rd_data;
      end
      if (emit) begin
         rsp_handle_ff <= emit_entry.handle_valid ? emit_entry.handle : '0;
         rsp_hv_ff     <= emit_entry.handle_valid;
         rsp_pos_ff    <= pos_ff;
         rsp_last_ff   <= emit_last;
      end
   end

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.moved_handle       = rsp_handle_ff;
   assign rsp_chan.moved_handle_valid = rsp_hv_ff;
   assign rsp_chan.new_position       = rsp_pos_ff;
   assign rsp_chan.last               = rsp_last_ff;

   mhpu_ram #(
      .WIDTH (ENTRY_WIDTH),
      .DEPTH (CAPACITY)
   ) u_heap_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

`ifndef SYNTHESIS
   a_no_same_slot: assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en) |-> (rd_addr != wr_addr))
      else $error("read and write-back hit the same heap slot");

   a_sift_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UP || state_ff == S_DN_L || state_ff == S_DN_R ||
       state_ff == S_DN_CMP) |-> ({1'b0, pos_ff} < count_ff))
      else $error("sift position outside the live entries");

   a_cmp_after_reads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DN_CMP) |->
      ($past(state_ff) == S_DN_R || $past(state_ff) == S_DN_CMP))
      else $error("compare entered without child reads");

   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      emit |-> (!rsp_valid_ff || rsp_chan.ready))
      else $error("result overwrites a pending result");
`endif

endmodule

>>> rtl/mhpu_ram.sv
module mhpu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> verif/tb_min_heap_position_update_core.sv
`timescale 1ns / 1ps

module tb_min_heap_position_update_core;
   import mhpu_pkg::*;

   localparam int RANDOM_UPDATES = 260;
   localparam int CALM_TAIL      = 40;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int LONG_HOLD      = 400;

   typedef struct packed {
      logic [POS_WIDTH-1:0]    position;
      logic [KEY_WIDTH-1:0]    key;
      logic [HANDLE_WIDTH-1:0] handle;
      logic                    handle_valid;
      logic [COUNT_WIDTH-1:0]  entry_count;
   } update_type;

   typedef struct packed {
      logic [HANDLE_WIDTH-1:0] moved_handle;
      logic                    moved_handle_valid;
      logic [POS_WIDTH-1:0]    new_position;
      logic                    last;
   } placement_type;

   class heap_move_scoreboard;
      logic [KEY_WIDTH-1:0]    keys    [CAPACITY];
      logic [HANDLE_WIDTH-1:0] handles [CAPACITY];
      logic                    hvalid  [CAPACITY];
      bit                      written [CAPACITY];
      placement_type           expected_moves [$];
      int                      errors;

      function new();
         foreach (written[i]) written[i] = 1'b0;
         errors = 0;
      endfunction

      function void place(int unsigned slot, logic [KEY_WIDTH-1:0] k,
                          logic [HANDLE_WIDTH-1:0] h, logic hv, logic fin);
         placement_type p;
         keys[slot]    = k;
         handles[slot] = h;
         hvalid[slot]  = hv;
         written[slot] = 1'b1;
         p.moved_handle       = hv ? h : '0;
         p.moved_handle_valid = hv;
         p.new_position       = POS_WIDTH'(slot);
         p.last               = fin;
         expected_moves.push_back(p);
      endfunction

      // Walk the sift path; commit applies it and queues the placements,
      // otherwise only report whether every slot read has been written.
      function bit sift_entry(update_type u, bit commit);
         int unsigned pos;
         int unsigned count;
         int unsigned par;
         int unsigned lc;
         int unsigned rc;
         int unsigned best;
         logic [KEY_WIDTH-1:0] best_key;
         pos   = u.position;
         count = u.entry_count;
         if (count > CAPACITY) count = CAPACITY;
         if (pos >= count) begin
            if (commit) place(pos, u.key, u.handle, u.handle_valid, 1'b1);
            return 1'b1;
         end
         if (pos > 0 && !written[(pos - 1) / 2]) return 1'b0;
         if (pos > 0 && keys[(pos - 1) / 2] > u.key) begin
            while (pos > 0) begin
               par = (pos - 1) / 2;
               if (!written[par]) return 1'b0;
               if (!(keys[par] > u.key)) break;
               if (commit) place(pos, keys[par], handles[par], hvalid[par], 1'b0);
               pos = par;
            end
         end else begin
            forever begin
               lc       = 2 * pos + 1;
               rc       = 2 * pos + 2;
               best     = pos;
               best_key = u.key;
               if (lc < count) begin
                  if (!written[lc]) return 1'b0;
                  if (keys[lc] < best_key) begin
                     best     = lc;
                     best_key = keys[lc];
                  end
               end
               if (rc < count) begin
                  if (!written[rc]) return 1'b0;
                  if (keys[rc] < best_key) best = rc;
               end
               if (best == pos) break;
               if (commit) place(pos, keys[best], handles[best], hvalid[best], 1'b0);
               pos = best;
            end
         end
         if (commit) place(pos, u.key, u.handle, u.handle_valid, 1'b1);
         return 1'b1;
      endfunction

      function void note_update(update_type u);
         void'(sift_entry(u, 1'b1));
      endfunction

      function void check_move(placement_type got);
         placement_type want;
         if (expected_moves.size() == 0) begin
            if (errors < 10)
               $display("unexpected placement: handle %h valid %b slot %0d last %b",
                        got.moved_handle, got.moved_handle_valid, got.new_position,
                        got.last);
            errors++;
            return;
         end
         want = expected_moves.pop_front();
         if (got.moved_handle !== want.moved_handle ||
             got.moved_handle_valid !== want.moved_handle_valid ||
             got.new_position !== want.new_position || got.last !== want.last) begin
            if (errors < 10) begin
               $write("placement mismatch: expected handle %h valid %b slot %0d last %b, ",
                      want.moved_handle, want.moved_handle_valid, want.new_position,
                      want.last);
               $display("got handle %h valid %b slot %0d last %b",
                        got.moved_handle, got.moved_handle_valid,
                        got.new_position, got.last);
            end
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   mhpu_req_if req_bus ();
   mhpu_rsp_if rsp_bus ();

   min_heap_position_update_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   heap_move_scoreboard sb = new();

   int unsigned heap_size   = 0;
   int          sent_count  = 0;
   int          total_items = 0;
   int          stall_left  = 0;
   bit          calm        = 1'b0;
   bit          hold_off    = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Long receiver hold-off: the block fills up and must stall its input.
   initial begin
      wait (sent_count >= 80);
      hold_off = 1'b1;
      repeat (LONG_HOLD) @(posedge clock);
      hold_off = 1'b0;
   end

   always @(negedge clock) begin
      if (reset || hold_off) begin
         rsp_bus.ready <= 1'b0;
      end else if (calm) begin
         rsp_bus.ready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left = $urandom_range(1, 12) - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      placement_type got;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got.moved_handle       = rsp_bus.moved_handle;
         got.moved_handle_valid = rsp_bus.moved_handle_valid;
         got.new_position       = rsp_bus.new_position;
         got.last               = rsp_bus.last;
         sb.check_move(got);
      end
   end

   task automatic send_update(update_type u);
      req_bus.valid        <= 1'b1;
      req_bus.position     <= u.position;
      req_bus.key          <= u.key;
      req_bus.handle       <= u.handle;
      req_bus.handle_valid <= u.handle_valid;
      req_bus.entry_count  <= u.entry_count;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sb.note_update(u);
      sent_count++;
      calm = (sent_count >= total_items - CALM_TAIL);
      @(negedge clock);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   endtask

   task automatic send_fields(int unsigned pos, logic [KEY_WIDTH-1:0] k,
                              logic [HANDLE_WIDTH-1:0] h, logic hv, int unsigned count);
      update_type u;
      u.position     = POS_WIDTH'(pos);
      u.key          = k;
      u.handle       = h;
      u.handle_valid = hv;
      u.entry_count  = COUNT_WIDTH'(count);
      send_update(u);
   endtask

   function automatic logic [KEY_WIDTH-1:0] random_key();
      logic [KEY_WIDTH-1:0] k;
      case ($urandom_range(0, 3))
         0: k = 64'($urandom_range(0, 15));
         1: k = {$urandom, $urandom};
         2: k = {32'hFFFF_FFFF, $urandom};
         default: k = 64'($urandom_range(0, 255));
      endcase
      return k;
   endfunction

   // Mostly well-formed heap traffic (append, re-key, pop via root), some noise.
   function automatic update_type next_random_update();
      update_type u;
      int         pick;
      pick           = $urandom_range(0, 99);
      u.key          = random_key();
      u.handle       = HANDLE_WIDTH'($urandom_range(0, 65535));
      u.handle_valid = ($urandom_range(0, 3) != 0);
      if (pick < 48 && heap_size < CAPACITY) begin
         u.position    = POS_WIDTH'(heap_size);
         u.entry_count = COUNT_WIDTH'(heap_size + 1);
         heap_size++;
      end else if (pick < 73 && heap_size > 0) begin
         u.position    = POS_WIDTH'($urandom_range(0, heap_size - 1));
         u.entry_count = COUNT_WIDTH'(heap_size);
      end else if (pick < 85 && heap_size > 1) begin
         u.position     = '0;
         u.key          = sb.keys[heap_size - 1];
         u.handle       = sb.handles[heap_size - 1];
         u.handle_valid = sb.hvalid[heap_size - 1];
         u.entry_count  = COUNT_WIDTH'(heap_size - 1);
         heap_size--;
      end else begin
         u.position    = POS_WIDTH'($urandom_range(0, CAPACITY - 1));
         u.entry_count = COUNT_WIDTH'($urandom_range(0, 2047));
         // drop to a plain slot write when the walk would touch unwritten slots
         if (!sb.sift_entry(u, 1'b0)) u.entry_count = COUNT_WIDTH'(u.position);
      end
      return u;
   endfunction

   initial begin
      int unsigned chain [8];
      chain                = '{3, 7, 15, 31, 63, 127, 255, 511};
      req_bus.valid        = 1'b0;
      req_bus.position     = '0;
      req_bus.key          = '0;
      req_bus.handle       = '0;
      req_bus.handle_valid = 1'b0;
      req_bus.entry_count  = '0;
      total_items          = 21 + RANDOM_UPDATES;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // write the ancestor chain of the deepest slot, zero and small counts
      send_fields(0, 64'd5, 16'hFFFF, 1'b1, 0);
      send_fields(1, 64'd10, 16'h1234, 1'b0, 1);
      foreach (chain[i])
         send_fields(chain[i], 64'(20 + i), HANDLE_WIDTH'($urandom), 1'b1, 0);
      send_fields(CAPACITY - 1, '1, 16'hA5A5, 1'b1, CAPACITY - 1);
      // full-depth sift up with saturated count
      send_fields(CAPACITY - 1, '0, 16'h0001, 1'b1, 2047);
      send_fields(CAPACITY - 1, '1, 16'h8000, 1'b1, CAPACITY);
      // equal keys: left child wins the tie
      send_fields(2, 64'd7, 16'h0202, 1'b1, 0);
      send_fields(1, 64'd7, 16'h0101, 1'b1, 0);
      send_fields(0, 64'd50, 16'h0050, 1'b1, 3);
      // right child strictly smaller than both
      send_fields(2, 64'd3, 16'h0303, 1'b0, 0);
      send_fields(0, 64'd60, 16'h0060, 1'b1, 3);
      send_fields(1, '0, 16'h7FFF, 1'b1, 3);
      // key equal to parent: no sift up
      send_fields(2, '0, 16'h4444, 1'b1, 3);
      send_fields(5, 64'd9, 16'h5555, 1'b1, 5);

      repeat (RANDOM_UPDATES) send_update(next_random_update());
      req_bus.valid <= 1'b0;

      while (sb.expected_moves.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.expected_moves.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> sim.f
rtl/mhpu_pkg.sv
rtl/mhpu_req_if.sv
rtl/mhpu_rsp_if.sv
rtl/mhpu_ram.sv
rtl/min_heap_position_update_core.sv
verif/tb_min_heap_position_update_core.sv
